// ----- rtl/utf8d_pkg.sv -----
`default_nettype none

package utf8d_pkg;

    localparam int CODE_W  = 21;
    localparam int MAX_RES = 4;
    localparam int HELD_N  = 3;

    localparam logic [1:0] MODE_REPLACE = 2'd0;
    localparam logic [1:0] MODE_PASS    = 2'd1;
    localparam logic [1:0] MODE_STRICT  = 2'd2;

    localparam logic [1:0] REG_ERROR_MODE  = 2'd0;
    localparam logic [1:0] REG_OUTPUT_UTF16 = 2'd1;
    localparam logic [1:0] REG_REPLACEMENT = 2'd2;

    localparam logic [15:0] REPL_RESET = 16'hFFFD;

    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] BAD_LEAD_MAX = 8'hC1;
    localparam logic [7:0] LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] LEAD3_MAX  = 8'hEF;
    localparam logic [7:0] LEAD4_MAX  = 8'hF4;
    localparam logic [7:0] LEAD_E0    = 8'hE0;
    localparam logic [7:0] LEAD_ED    = 8'hED;
    localparam logic [7:0] LEAD_F0    = 8'hF0;
    localparam logic [7:0] LEAD_F4    = 8'hF4;
    localparam logic [7:0] CONT_LO    = 8'h80;
    localparam logic [7:0] CONT_HI    = 8'hBF;
    localparam logic [7:0] CONT_LO_E0 = 8'hA0;
    localparam logic [7:0] CONT_HI_ED = 8'h9F;
    localparam logic [7:0] CONT_LO_F0 = 8'h90;
    localparam logic [7:0] CONT_HI_F4 = 8'h8F;

    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;

    typedef struct packed {
        logic [1:0]  error_mode;
        logic        output_utf16;
        logic [15:0] replacement_unit;
    } cfg_t;

    typedef struct packed {
        logic [MAX_RES-1:0][CODE_W-1:0] unit;
        logic [2:0]                     count;
        logic                           is_error;
        logic                           str_end;
    } bundle_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_unit;
        logic              is_error;
        logic              run_end;
        logic              string_end;
    } result_t;

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] n;
        if (b <= ASCII_MAX)
            n = 3'd1;
        else if (b <= BAD_LEAD_MAX)
            n = 3'd0;
        else if (b <= LEAD2_MAX)
            n = 3'd2;
        else if (b <= LEAD3_MAX)
            n = 3'd3;
        else if (b <= LEAD4_MAX)
            n = 3'd4;
        else
            n = 3'd0;
        return n;
    endfunction

    function automatic logic cont_ok(input logic [7:0] lead, input logic second,
                                     input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = CONT_LO;
        hi = CONT_HI;
        if (second)
        begin
            if (lead == LEAD_E0)
                lo = CONT_LO_E0;
            if (lead == LEAD_ED)
                hi = CONT_HI_ED;
            if (lead == LEAD_F0)
                lo = CONT_LO_F0;
            if (lead == LEAD_F4)
                hi = CONT_HI_F4;
        end
        return (b >= lo) && (b <= hi);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/utf8d_cfg.sv -----
`default_nettype none

module utf8d_cfg
    import utf8d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;
    logic       wr;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.error_mode       <= MODE_REPLACE;
            cfg_reg.output_utf16     <= 1'b0;
            cfg_reg.replacement_unit <= REPL_RESET;
        end
        else if (wr)
        begin
            unique case (reg_idx)
                REG_ERROR_MODE:   cfg_reg.error_mode       <= pwdata[1:0];
                REG_OUTPUT_UTF16: cfg_reg.output_utf16     <= pwdata[0];
                REG_REPLACEMENT:  cfg_reg.replacement_unit <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ERROR_MODE:   prdata = {30'd0, cfg_reg.error_mode};
            REG_OUTPUT_UTF16: prdata = {31'd0, cfg_reg.output_utf16};
            REG_REPLACEMENT:  prdata = {16'd0, cfg_reg.replacement_unit};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/utf8d_dec.sv -----
`default_nettype none

module utf8d_dec
    import utf8d_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire logic       advance,
    output bundle_t         bundle
);

    logic [HELD_N-1:0][7:0] held_reg;
    logic [HELD_N-1:0][7:0] held_next;
    logic [1:0]             cnt_reg;
    logic [1:0]             cnt_next;
    logic                   discarding_reg;
    logic                   discarding_next;

    function automatic logic [CODE_W-1:0] bad_unit(input logic [7:0] x, input cfg_t c);
        logic [CODE_W-1:0] u;
        if (c.error_mode == MODE_PASS)
            u = {{(CODE_W-8){1'b0}}, x};
        else
            u = {{(CODE_W-16){1'b0}}, c.replacement_unit};
        return u;
    endfunction

    always_comb
    begin
        logic [7:0]        lead;
        logic [2:0]        len;
        logic [2:0]        blen;
        logic [2:0]        cnt_p1;
        logic              b_ok;
        logic              has_held;
        logic              complete;
        logic              extend;
        logic              broken;
        logic              alone_emit;
        logic              alone_err;
        logic              alone_hold;
        logic [CODE_W-1:0] alone_unit;
        logic              err;
        logic              strict;
        logic [CODE_W-1:0] cp;
        logic [19:0]       v;

        lead     = held_reg[0];
        len      = seq_len(lead);
        blen     = seq_len(in_byte);
        cnt_p1   = {1'b0, cnt_reg} + 3'd1;
        b_ok     = cont_ok(lead, cnt_reg == 2'd1, in_byte);
        has_held = cnt_reg != 2'd0;
        complete = has_held && b_ok && (cnt_p1 == len);
        extend   = has_held && b_ok && (cnt_p1 < len) && !in_last;
        broken   = has_held && !complete && !extend;
        strict   = cfg.error_mode >= MODE_STRICT;

        // a byte examined on its own as a new sequence
        alone_emit = 1'b1;
        alone_err  = 1'b0;
        alone_hold = 1'b0;
        alone_unit = {{(CODE_W-8){1'b0}}, in_byte};
        if (blen == 3'd0)
        begin
            alone_err  = 1'b1;
            alone_unit = bad_unit(in_byte, cfg);
        end
        else if (blen != 3'd1)
        begin
            if (in_last)
            begin
                alone_err  = 1'b1;
                alone_unit = bad_unit(in_byte, cfg);
            end
            else
            begin
                alone_emit = 1'b0;
                alone_hold = 1'b1;
            end
        end

        err = broken || (!has_held && alone_err);

        unique case (len)
            3'd2:    cp = {10'd0, lead[4:0], in_byte[5:0]};
            3'd3:    cp = {5'd0, lead[3:0], held_reg[1][5:0], in_byte[5:0]};
            default: cp = {lead[2:0], held_reg[1][5:0], held_reg[2][5:0], in_byte[5:0]};
        endcase
        v = cp[19:0] - 20'h10000;

        bundle.unit     = '0;
        bundle.count    = 3'd0;
        bundle.is_error = 1'b0;
        bundle.str_end  = in_last;
        held_next       = held_reg;
        cnt_next        = cnt_reg;
        discarding_next = discarding_reg;

        if (discarding_reg)
        begin
            if (in_last)
                discarding_next = 1'b0;
        end
        else if (err && strict)
        begin
            bundle.count    = 3'd1;
            bundle.is_error = 1'b1;
            bundle.str_end  = 1'b1;
            held_next       = '0;
            cnt_next        = 2'd0;
            discarding_next = !in_last;
        end
        else if (complete)
        begin
            cnt_next = 2'd0;
            if (cfg.output_utf16 && (cp[20:16] != 5'd0))
            begin
                bundle.unit[0] = {5'd0, SURR_HI_BASE[15:10], v[19:10]};
                bundle.unit[1] = {5'd0, SURR_LO_BASE[15:10], cp[9:0]};
                bundle.count   = 3'd2;
            end
            else
            begin
                bundle.unit[0] = cp;
                bundle.count   = 3'd1;
            end
        end
        else if (extend)
        begin
            held_next[cnt_reg] = in_byte;
            cnt_next           = cnt_p1[1:0];
        end
        else if (broken)
        begin
            // each held byte becomes a bad item, then the new byte starts afresh
            for (int i = 0; i < HELD_N; i++)
            begin
                if (i < int'(cnt_reg))
                    bundle.unit[i] = bad_unit(held_reg[i], cfg);
            end
            if (alone_emit)
                bundle.unit[cnt_reg] = alone_unit;
            bundle.count = {1'b0, cnt_reg} + {2'd0, alone_emit};
            cnt_next     = {1'b0, alone_hold};
            held_next[0] = in_byte;
        end
        else
        begin
            bundle.unit[0] = alone_unit;
            bundle.count   = {2'd0, alone_emit};
            cnt_next       = {1'b0, alone_hold};
            held_next[0]   = in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= '0;
            cnt_reg        <= 2'd0;
            discarding_reg <= 1'b0;
        end
        else if (advance)
        begin
            held_reg       <= held_next;
            cnt_reg        <= cnt_next;
            discarding_reg <= discarding_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/utf8d_ser.sv -----
`default_nettype none

module utf8d_ser
    import utf8d_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire bundle_t bundle,
    input  wire logic    load,
    output logic         ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      result
);

    bundle_t    bundle_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       final_item;
    logic       take;

    assign final_item = ({1'b0, idx_reg} == (bundle_reg.count - 3'd1));
    assign ready      = !valid_reg || (out_ready && final_item);
    assign take       = load && (bundle.count != 3'd0);
    assign out_valid  = valid_reg;

    assign result.code_unit  = bundle_reg.unit[idx_reg];
    assign result.is_error   = bundle_reg.is_error;
    assign result.run_end    = final_item;
    assign result.string_end = final_item && bundle_reg.str_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end
        else if (valid_reg && out_ready)
        begin
            if (final_item)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            bundle_reg <= bundle;
    end

endmodule

`default_nettype wire

// ----- rtl/utf8_validating_decoder_core.sv -----
`default_nettype none

// the input byte is registered, then decoded and loaded into the result register that offers it
// throughput: one byte per cycle while each byte gives at most one result and the
// receiver is ready; a byte giving more results holds the input while the result
// register drains one unit per cycle while m_axis_tready is high
// reset: asynchronous, clears held bytes, discard state and the registers to defaults

module utf8_validating_decoder_core
    import utf8d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // byte_in
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // code_unit[20:0], run_end[21], zero[23:22]
    output logic             m_axis_tuser,  // is_error
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t       cfg;
    bundle_t    bundle;
    result_t    result;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       ser_ready;
    logic       advance;
    logic       s_take;

    assign advance       = in_valid_reg && ser_ready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    utf8d_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    utf8d_dec u_dec (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .advance (advance),
        .bundle  (bundle)
    );

    utf8d_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .bundle    (bundle),
        .load      (advance),
        .ready     (ser_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    assign m_axis_tdata = {2'b00, result.run_end, result.code_unit};
    assign m_axis_tuser = result.is_error;
    assign m_axis_tlast = result.string_end;

endmodule

`default_nettype wire

// ----- test/utf8_decode_checker.sv -----
module utf8_decode_checker
    import utf8d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // byte_in
    input  wire logic        s_tlast,   // string_last
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,   // code_unit[20:0], run_end[21], zero[23:22]
    input  wire logic        m_tuser,   // is_error
    input  wire logic        m_tlast,   // string_end
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               mismatches,
    output int               outstanding
);

    logic [1:0]      mode_q;
    logic            utf16_q;
    logic [15:0]     repl_q;
    logic [2:0][7:0] held;
    int              held_n;
    logic            dropping;
    int              fail_n;
    result_t         expected_units[$];
    result_t         head;

    function automatic int lead_len(input logic [7:0] b);
        if (b <= ASCII_MAX)
            return 1;
        if (b <= BAD_LEAD_MAX)
            return 0;
        if (b <= LEAD2_MAX)
            return 2;
        if (b <= LEAD3_MAX)
            return 3;
        if (b <= LEAD4_MAX)
            return 4;
        return 0;
    endfunction

    function automatic logic follow_ok(input logic [7:0] lead, input int pos,
                                       input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = CONT_LO;
        hi = CONT_HI;
        if (pos == 1)
        begin
            case (lead)
                LEAD_E0: lo = CONT_LO_E0;
                LEAD_ED: hi = CONT_HI_ED;
                LEAD_F0: lo = CONT_LO_F0;
                LEAD_F4: hi = CONT_HI_F4;
                default: ;
            endcase
        end
        return (b >= lo) && (b <= hi);
    endfunction

    function automatic logic [20:0] assemble(input logic [3:0][7:0] s, input int len);
        logic [20:0] cp;
        case (len)
            1:       cp = {13'd0, s[0]};
            2:       cp = {10'd0, s[0][4:0], s[1][5:0]};
            3:       cp = {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
            default: cp = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
        endcase
        return cp;
    endfunction

    // works out the units one accepted byte gives and queues them
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [3:0][7:0] seq;
        int              cnt;
        int              len;
        int              shift;
        logic            ok;
        logic [20:0]     cp;
        logic [20:0]     v;
        result_t         u;
        result_t         batch[$];
        if (dropping)
        begin
            if (last)
                dropping = 1'b0;
            return;
        end
        seq = '0;
        for (int i = 0; i < held_n; i++)
            seq[i] = held[i];
        seq[held_n] = b;
        cnt = held_n + 1;
        while (cnt > 0)
        begin
            len = lead_len(seq[0]);
            ok = (len != 0);
            for (int k = 1; ok && k < cnt && k < len; k++)
                ok = follow_ok(seq[0], k, seq[k]);
            if (ok && cnt < len)
            begin
                if (!last)
                    break;
                ok = 1'b0;
            end
            u = '0;
            if (ok)
            begin
                cp = assemble(seq, len);
                if (utf16_q && cp >= 21'h10000)
                begin
                    v = cp - 21'h10000;
                    u.code_unit = SURR_HI_BASE + v[19:10];
                    batch = {batch, u};
                    u.code_unit = SURR_LO_BASE + cp[9:0];
                    batch = {batch, u};
                end
                else
                begin
                    u.code_unit = cp;
                    batch = {batch, u};
                end
                shift = len;
            end
            else if (mode_q >= MODE_STRICT)
            begin
                // strict: single error unit ends the string, rest dropped
                u.is_error = 1'b1;
                u.run_end = 1'b1;
                u.string_end = 1'b1;
                expected_units = {expected_units, u};
                held = '0;
                held_n = 0;
                dropping = !last;
                return;
            end
            else
            begin
                u.code_unit = (mode_q == MODE_PASS) ? 21'(seq[0]) : 21'(repl_q);
                batch = {batch, u};
                shift = 1;
            end
            seq = seq >> (8 * shift);
            cnt -= shift;
        end
        held = '0;
        for (int i = 0; i < cnt; i++)
            held[i] = seq[i];
        held_n = cnt;
        if (batch.size() > 0)
        begin
            u = batch.pop_back();
            u.run_end = 1'b1;
            u.string_end = last;
            batch = {batch, u};
        end
        foreach (batch[i])
            expected_units = {expected_units, batch[i]};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q = MODE_REPLACE;
            utf16_q = 1'b0;
            repl_q = REPL_RESET;
            held = '0;
            held_n = 0;
            dropping = 1'b0;
            fail_n = 0;
            expected_units.delete();
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_ERROR_MODE:   mode_q = pwdata[1:0];
                    REG_OUTPUT_UTF16: utf16_q = pwdata[0];
                    REG_REPLACEMENT:  repl_q = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (expected_units.size() == 0)
                begin
                    fail_n++;
                    $error("unexpected transfer: code_unit %h is_error %b",
                           m_tdata[20:0], m_tuser);
                end
                else
                begin
                    head = expected_units.pop_front();
                    if (m_tdata[20:0] !== head.code_unit)
                    begin
                        fail_n++;
                        $error("code_unit: expected %h, got %h", head.code_unit, m_tdata[20:0]);
                    end
                    if (m_tuser !== head.is_error)
                    begin
                        fail_n++;
                        $error("is_error: expected %b, got %b", head.is_error, m_tuser);
                    end
                    if (m_tdata[21] !== head.run_end)
                    begin
                        fail_n++;
                        $error("run_end: expected %b, got %b", head.run_end, m_tdata[21]);
                    end
                    if (m_tlast !== head.string_end)
                    begin
                        fail_n++;
                        $error("string_end: expected %b, got %b", head.string_end, m_tlast);
                    end
                end
            end
            mismatches <= fail_n;
            outstanding <= expected_units.size();
        end
    end

endmodule

// ----- test/utf8_validating_decoder_core_tb.sv -----
module utf8_validating_decoder_core_tb;
    import utf8d_pkg::*;

    localparam logic [1:0] MODE_STRICT_ALT = 2'd3;
    localparam logic [1:0] REG_UNUSED      = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // byte_in
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // code_unit[20:0], run_end[21], zero[23:22]
    logic        m_axis_tuser;   // is_error
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          outstanding;
    logic [7:0]  str_bytes[$];
    int          burst_left;
    bit          hold_req;

    utf8_validating_decoder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    utf8_decode_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .s_tlast     (s_axis_tlast),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .m_tuser     (m_axis_tuser),
        .m_tlast     (m_axis_tlast),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("utf8_validating_decoder_core_tb: done, errors");
        $finish;
    end

    // receiver: stall pattern of its own, plus one long hold-off on request
    initial
    begin
        logic [15:0] pat;
        int          ph;
        m_axis_tready = 1'b0;
        pat = '1;
        ph = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (ph == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       pat = '1;
                        1:       pat = 16'($urandom) | 16'h0101;
                        2:       pat = 16'h8000;
                        default: pat = 16'($urandom) | 16'h0001;
                    endcase
                end
                m_axis_tready <= pat[ph % 16];
                ph = (ph + 1) % 64;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
    endtask

    task automatic send_str();
        foreach (str_bytes[i])
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
    endtask

    // idle until every expected unit has come and any held bytes have settled
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // junk above each register's width checks that only the low bits are kept
    task automatic set_config(input logic [1:0] mode, input logic utf16,
                              input logic [15:0] repl);
        logic [31:0] junk;
        junk = $urandom;
        reg_write(REG_ERROR_MODE, {junk[31:2], mode});
        junk = $urandom;
        reg_write(REG_OUTPUT_UTF16, {junk[31:1], utf16});
        junk = $urandom;
        reg_write(REG_REPLACEMENT, {junk[31:16], repl});
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    task automatic add_byte(input logic [7:0] b);
        str_bytes = {str_bytes, b};
    endtask

    task automatic push_valid(input int len);
        logic [7:0] lead;
        case (len)
            1:
                add_byte(8'($urandom_range(0, 127)));
            2:
            begin
                add_byte(8'($urandom_range(8'hC2, 8'hDF)));
                add_byte(cont_byte());
            end
            3:
            begin
                lead = 8'($urandom_range(8'hE0, 8'hEF));
                add_byte(lead);
                if (lead == LEAD_E0)
                    add_byte(8'($urandom_range(8'hA0, 8'hBF)));
                else if (lead == LEAD_ED)
                    add_byte(8'($urandom_range(8'h80, 8'h9F)));
                else
                    add_byte(cont_byte());
                add_byte(cont_byte());
            end
            default:
            begin
                lead = 8'($urandom_range(8'hF0, 8'hF4));
                add_byte(lead);
                if (lead == LEAD_F0)
                    add_byte(8'($urandom_range(8'h90, 8'hBF)));
                else if (lead == LEAD_F4)
                    add_byte(8'($urandom_range(8'h80, 8'h8F)));
                else
                    add_byte(cont_byte());
                add_byte(cont_byte());
                add_byte(cont_byte());
            end
        endcase
    endtask

    task automatic push_broken();
        int len;
        int pos;
        case ($urandom_range(0, 4))
            0:
                add_byte(8'($urandom_range(0, 255)));
            1:
            begin
                // bad lead: C0, C1, F5 and up, or a stray continuation
                case ($urandom_range(0, 2))
                    0:       add_byte(8'($urandom_range(8'hC0, 8'hC1)));
                    1:       add_byte(8'($urandom_range(8'hF5, 8'hFF)));
                    default: add_byte(cont_byte());
                endcase
            end
            2:
            begin
                // truncated sequence
                len = $urandom_range(2, 4);
                push_valid(len);
                repeat ($urandom_range(1, len - 1)) void'(str_bytes.pop_back());
            end
            3:
            begin
                // overlong, surrogate or beyond U+10FFFF
                case ($urandom_range(0, 3))
                    0:
                    begin
                        add_byte(LEAD_E0);
                        add_byte(8'($urandom_range(8'h80, 8'h9F)));
                        add_byte(cont_byte());
                    end
                    1:
                    begin
                        add_byte(LEAD_ED);
                        add_byte(8'($urandom_range(8'hA0, 8'hBF)));
                        add_byte(cont_byte());
                    end
                    2:
                    begin
                        add_byte(LEAD_F0);
                        add_byte(8'($urandom_range(8'h80, 8'h8F)));
                        add_byte(cont_byte());
                        add_byte(cont_byte());
                    end
                    default:
                    begin
                        add_byte(LEAD_F4);
                        add_byte(8'($urandom_range(8'h90, 8'hBF)));
                        add_byte(cont_byte());
                        add_byte(cont_byte());
                    end
                endcase
            end
            default:
            begin
                // one continuation swapped for a non-continuation byte
                len = $urandom_range(2, 4);
                push_valid(len);
                pos = str_bytes.size() - len + $urandom_range(1, len - 1);
                str_bytes[pos] = $urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                                      : 8'($urandom_range(192, 255));
            end
        endcase
    endtask

    task automatic run_random(input int nbytes);
        int sent;
        sent = 0;
        while (sent < nbytes)
        begin
            str_bytes.delete();
            repeat ($urandom_range(1, 8))
            begin
                if ($urandom_range(0, 99) < 75)
                    push_valid($urandom_range(1, 4));
                else
                    push_broken();
            end
            send_str();
            sent += str_bytes.size();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 0;
        hold_req = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: boundary code points of each length
        str_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F, 8'hBF,
                      8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_str();
        // bad lead, then a sequence cut short by the end of the string
        str_bytes = '{8'hFF, 8'hE0, 8'hA0};
        send_str();
        settle();

        // long receiver hold-off while the sender keeps offering
        set_config(MODE_REPLACE, 1'b1, REPL_RESET);
        hold_req = 1'b1;
        burst_left = 200;
        run_random(30);
        settle();

        set_config(MODE_PASS, 1'b0, 16'h0000);
        run_random(25);
        settle();

        // strict error at the start of a string, rest of the string dropped
        set_config(MODE_STRICT, 1'b1, 16'hFFFF);
        str_bytes = '{8'hC0, 8'h41};
        send_str();
        run_random(30);
        settle();

        reg_write(REG_UNUSED, $urandom);
        set_config(MODE_STRICT_ALT, 1'b0, 16'($urandom));
        run_random(25);
        settle();

        set_config(MODE_REPLACE, 1'b0, 16'h0000);
        run_random(25);
        settle();

        set_config(MODE_PASS, 1'b1, 16'hFFFF);
        run_random(25);
        settle();

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("utf8_validating_decoder_core_tb: done, clean");
        else
            $display("utf8_validating_decoder_core_tb: done, errors");
        $finish;
    end

endmodule
